### hdl/kth_smallest_selection_defines.svh
// Assertion macros for the kth_smallest_selection RTL (used by kss_ctrl).
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef KTH_SMALLEST_SELECTION_DEFINES_SVH
`define KTH_SMALLEST_SELECTION_DEFINES_SVH

// Checked only outside reset.
`define KSS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define KSS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/kss_pkg.sv
// Shared constants and controller/datapath interface types for kth_smallest_selection.
// No dependencies.
`default_nettype none
package kss_pkg;
    localparam int MAX_ITEMS = 256;
    localparam int DATA_W    = 32;
    localparam int RANK_W    = 9;
    localparam int ADDR_W    = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = ADDR_W + 1;
    localparam int CMP_W     = (RANK_W > CNT_W) ? RANK_W : CNT_W;

    typedef struct packed {
        logic load;       // input transfer: store and count value unless store full (then overflow)
        logic start;      // set closed: latch n, k, flags; clear set state
        logic scan;       // issue one store read and advance the address
        logic next_pass;  // commit pass winner as lower bound, rewind
        logic push;       // move result into the output register
    } t_cmd;

    typedef struct packed {
        logic addr_last;  // address being issued is the last stored entry
        logic last_pass;  // current pass yields the result
        logic rd_busy;    // a read is in flight to the compare stage
        logic out_full;   // output register holds a result not yet taken
    } t_sts;
endpackage
`default_nettype wire

### hdl/kss_ctrl.sv
// Sequencer for kth_smallest_selection: load, scan passes, result hand-off.
// Depends on kss_pkg and kth_smallest_selection_defines.svh.
`default_nettype none
`include "kth_smallest_selection_defines.svh"
module kss_ctrl (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    input  wire           i_in_last,
    output logic          o_in_ready,
    input  kss_pkg::t_sts i_sts,
    output kss_pkg::t_cmd o_cmd
);
    import kss_pkg::*;

    localparam logic [2:0] ST_LOAD = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_EVAL = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       w_acc;

    assign o_in_ready = (r_state == ST_LOAD);
    assign w_acc      = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_LOAD: begin
                if (w_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.start = 1'b1;
                        n_state     = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.addr_last) begin
                    n_state = ST_WAIT;
                end
            end
            // last read data is compared here
            ST_WAIT: n_state = ST_EVAL;
            ST_EVAL: begin
                if (i_sts.last_pass) begin
                    n_state = ST_PUSH;
                end else begin
                    o_cmd.next_pass = 1'b1;
                    n_state         = ST_SCAN;
                end
            end
            ST_PUSH: begin
                if (!i_sts.out_full) begin
                    o_cmd.push = 1'b1;
                    n_state    = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    `KSS_ASSERT_ALWAYS(a_rst_load, !i_rst_n |=> r_state == ST_LOAD, "reset must return to load")
    `KSS_ASSERT(a_close_scans, (w_acc && i_in_last) |=> r_state == ST_SCAN, "closing item must start a scan")
    `KSS_ASSERT(a_eval_drained, r_state == ST_EVAL |-> !i_sts.rd_busy, "pass evaluated with read in flight")
    `KSS_ASSERT(a_push_free, o_cmd.push |-> !i_sts.out_full, "result pushed over unread result")
endmodule
`default_nettype wire

### hdl/kss_dp.sv
// Datapath for kth_smallest_selection: value store, counters, ordered-min/max search, output register.
// Depends on kss_pkg.
`default_nettype none
module kss_dp (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  kss_pkg::t_cmd                       i_cmd,
    output kss_pkg::t_sts                       o_sts,
    input  wire        [kss_pkg::RANK_W-1:0]    i_rank,
    input  wire signed [kss_pkg::DATA_W-1:0]    i_sample,
    input  wire                                 i_out_ready,
    output logic                                o_out_valid,
    output logic signed [kss_pkg::DATA_W-1:0]   o_sel_value,
    output logic                                o_clip,
    output logic                                o_ovf
);
    import kss_pkg::*;

    logic signed [DATA_W-1:0] mem [MAX_ITEMS];

    logic [CNT_W-1:0]          r_count;
    logic                      r_ovf;
    logic [CNT_W-1:0]          r_n;
    logic [CMP_W-1:0]          r_k;
    logic                      r_clip;
    logic                      r_ovf_res;
    logic [ADDR_W-1:0]         r_addr;
    logic [CNT_W-1:0]          r_pass;
    logic                      r_rd_vld;
    logic [ADDR_W-1:0]         r_rd_idx;
    logic signed [DATA_W-1:0]  r_rd_data;
    logic                      r_have_prev;
    logic signed [DATA_W-1:0]  r_prev_v;
    logic [ADDR_W-1:0]         r_prev_i;
    logic                      r_best_valid;
    logic signed [DATA_W-1:0]  r_best_v;
    logic [ADDR_W-1:0]         r_best_i;
    logic                      r_out_valid;
    logic signed [DATA_W-1:0]  r_out_v;
    logic                      r_out_clip;
    logic                      r_out_ovf;

    logic                      w_full;
    logic [CNT_W-1:0]          w_n_end;
    logic [CMP_W-1:0]          w_k_eff;
    logic                      w_above;
    logic                      w_take;

    assign w_full  = (r_count == CNT_W'(MAX_ITEMS));
    assign w_n_end = w_full ? r_count : r_count + CNT_W'(1);
    assign w_k_eff = (i_rank == '0) ? CMP_W'(1) : CMP_W'(i_rank);

    // candidate must lie above the previous winner in (value, index) order
    assign w_above = !r_have_prev || (r_rd_data > r_prev_v)
                     || ((r_rd_data == r_prev_v) && (r_rd_idx > r_prev_i));
    assign w_take  = r_rd_vld && (r_clip ? (!r_best_valid || r_rd_data > r_best_v)
                                         : (w_above && (!r_best_valid || r_rd_data < r_best_v)));

    assign o_sts.addr_last = ({1'b0, r_addr} == (r_n - CNT_W'(1)));
    assign o_sts.last_pass = r_clip || (CMP_W'(r_pass) == (r_k - CMP_W'(1)));
    assign o_sts.rd_busy   = r_rd_vld;
    assign o_sts.out_full  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_sel_value = r_out_v;
    assign o_clip      = r_out_clip;
    assign o_ovf       = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && !w_full) begin
            mem[r_count[ADDR_W-1:0]] <= i_sample;
        end
        if (i_cmd.scan) begin
            r_rd_data <= mem[r_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_have_prev  <= 1'b0;
            r_best_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan;
            if (w_take) begin
                r_best_valid <= 1'b1;
            end
            if (i_cmd.start) begin
                r_count      <= '0;
                r_ovf        <= 1'b0;
                r_have_prev  <= 1'b0;
                r_best_valid <= 1'b0;
            end else if (i_cmd.load) begin
                if (w_full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_count <= r_count + CNT_W'(1);
                end
            end
            if (i_cmd.next_pass) begin
                r_have_prev  <= 1'b1;
                r_best_valid <= 1'b0;
            end
            if (i_cmd.push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_rd_idx <= r_addr;
        if (w_take) begin
            r_best_v <= r_rd_data;
            r_best_i <= r_rd_idx;
        end
        if (i_cmd.start) begin
            r_n       <= w_n_end;
            r_k       <= w_k_eff;
            r_clip    <= (w_k_eff >= CMP_W'(w_n_end));
            r_ovf_res <= r_ovf | w_full;
            r_addr    <= '0;
            r_pass    <= '0;
        end
        if (i_cmd.scan) begin
            r_addr <= r_addr + ADDR_W'(1);
        end
        if (i_cmd.next_pass) begin
            r_prev_v <= r_best_v;
            r_prev_i <= r_best_i;
            r_addr   <= '0;
            r_pass   <= r_pass + CNT_W'(1);
        end
        if (i_cmd.push) begin
            r_out_v    <= r_best_v;
            r_out_clip <= r_clip;
            r_out_ovf  <= r_ovf_res;
        end
    end
endmodule
`default_nettype wire

### hdl/kth_smallest_selection.sv
// kth_smallest_selection: one value per input transfer; tlast closes the set. Result per set.
// When rank >= n the result comes from one max pass over the store, else from rank passes of
// ordered-minimum search; each pass is one sweep of the store's read port.
// Input ready only while loading (1 cycle/item); output register frees the next set's load.
// i_rst_n synchronous active low: empty set, rank = 1, no result pending; store not cleared.
`default_nettype none
module kth_smallest_selection (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 s_axis_tvalid,
    output logic                                s_axis_tready,
    input  wire        [kss_pkg::DATA_W-1:0]    s_axis_tdata,   // [31:0] sample_value
    input  wire                                 s_axis_tlast,   // is_last
    output logic                                m_axis_tvalid,
    input  wire                                 m_axis_tready,
    output logic       [kss_pkg::DATA_W-1:0]    m_axis_tdata,   // [31:0] selected_value
    output logic       [1:0]                    m_axis_tuser,   // [0] rank_clipped, [1] overflow
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire        [kss_pkg::RANK_W-1:0]    i_cfg_data      // rank
);
    import kss_pkg::*;

    logic [RANK_W-1:0]        r_rank;
    t_cmd                     w_cmd;
    t_sts                     w_sts;
    logic signed [DATA_W-1:0] w_sel;
    logic                     w_clip;
    logic                     w_ovf;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= RANK_W'(1);
        end else if (i_cfg_valid) begin
            r_rank <= i_cfg_data;
        end
    end

    kss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    kss_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_rank      (r_rank),
        .i_sample    (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_sel_value (w_sel),
        .o_clip      (w_clip),
        .o_ovf       (w_ovf)
    );

    assign m_axis_tdata = w_sel;
    assign m_axis_tuser = {w_ovf, w_clip};
endmodule
`default_nettype wire
